### rtl/core/lsatc_pkg.sv
// ----------------------------------------------------------------------------
// lsatc_pkg: shared types and constants
// Codes, widths and result struct for the locked send / ack timeout control.
// ----------------------------------------------------------------------------
`default_nettype none

package lsatc_pkg;

    // Counter widths
    localparam int TICK_BITS  = 16;
    localparam int RETRY_BITS = 8;

    // Field and register widths
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int TIMEOUT_W  = 16;
    localparam int ACKRET_W   = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Compare widths wide enough for both sides
    localparam int TCMP_W = (TICK_BITS > TIMEOUT_W) ? TICK_BITS : TIMEOUT_W;
    localparam int RCMP_W = (RETRY_BITS > ACKRET_W) ? RETRY_BITS : ACKRET_W;

    localparam logic [TICK_BITS-1:0]  TICK_MAX  = {TICK_BITS{1'b1}};
    localparam logic [RETRY_BITS-1:0] RETRY_MAX = {RETRY_BITS{1'b1}};

    // Register reset values
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(100);
    localparam logic [ACKRET_W-1:0]  ACKRET_RST  = '0;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_START = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_ACK   = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // Completion status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_LOCK_TO   = 2'd1,
        ST_SEND_FAIL = 2'd2,
        ST_ACK_TO    = 2'd3
    } t_status;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT = 8'd0,
        CFG_RETRIES = 8'd1
    } t_cfg_idx;

    // Transaction phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_LOCK = 3'b010,
        PH_ACK  = 3'b100
    } t_phase;

    // One result item
    typedef struct packed {
        logic          claim;
        logic          send;
        logic          release_l;
        logic          busy;
        logic          done;
        t_status       status;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/lsatc_step.sv
// ----------------------------------------------------------------------------
// lsatc_step: transaction state and per-item update
// Holds phase, wait counter and retry count; computes one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module lsatc_step (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_advance,
    input  wire  [lsatc_pkg::REQ_W-1:0]          i_req_type,
    input  wire                                  i_lock_free,
    input  wire                                  i_send_ok,
    input  wire  [lsatc_pkg::TIMEOUT_W-1:0]      i_timeout_ticks,
    input  wire  [lsatc_pkg::ACKRET_W-1:0]       i_ack_retries,
    output lsatc_pkg::t_result                   o_result
);
    import lsatc_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [TICK_BITS-1:0]   r_tick, n_tick;
    logic [RETRY_BITS-1:0]  r_retries, n_retries;

    logic [TICK_BITS-1:0]   tick_inc;
    logic                   expired;
    logic [RETRY_BITS-1:0]  retry_load;
    logic                   do_claim;
    logic                   do_finish;
    t_status                fin_code;
    t_req                   req;

    assign req = t_req'(i_req_type);

    // Advance wait counter with saturation, detect expiry
    assign tick_inc = (r_tick != TICK_MAX) ? r_tick + 1'b1 : r_tick;
    assign expired  = (TCMP_W'(tick_inc) >= TCMP_W'(i_timeout_ticks)) ||
                      (tick_inc == TICK_MAX);

    // Saturate retry setting to counter width
    assign retry_load = (RCMP_W'(i_ack_retries) > RCMP_W'(RETRY_MAX)) ?
                        RETRY_MAX : RETRY_BITS'(RCMP_W'(i_ack_retries));

    // Next state and result for the item in the input register
    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_retries = r_retries;
        do_claim  = 1'b0;
        do_finish = 1'b0;
        fin_code  = ST_OK;
        o_result  = '0;

        case (r_phase)
            PH_LOCK: begin
                if (req == REQ_TICK) begin
                    n_tick = tick_inc;
                    if (expired) begin
                        if (i_lock_free) begin
                            do_claim = 1'b1;
                        end else begin
                            do_finish = 1'b1;
                            fin_code  = ST_LOCK_TO;
                        end
                    end
                end
            end
            PH_ACK: begin
                if (req == REQ_ACK) begin
                    o_result.release_l = 1'b1;
                    do_finish          = 1'b1;
                    fin_code           = ST_OK;
                end else if (req == REQ_TICK) begin
                    n_tick = tick_inc;
                    if (expired) begin
                        if (r_retries != '0) begin
                            n_retries = r_retries - 1'b1;
                            n_tick    = '0;
                        end else begin
                            o_result.release_l = 1'b1;
                            do_finish          = 1'b1;
                            fin_code           = ST_ACK_TO;
                        end
                    end
                end
            end
            default: begin
                // Idle, and any unused code behaves as idle
                n_phase = PH_IDLE;
                if (req == REQ_START) begin
                    if (i_lock_free) begin
                        do_claim = 1'b1;
                    end else begin
                        n_phase = PH_LOCK;
                        n_tick  = '0;
                    end
                end
            end
        endcase

        // Lock held: send in this item
        if (do_claim) begin
            o_result.claim = 1'b1;
            o_result.send  = 1'b1;
            if (i_send_ok) begin
                n_phase   = PH_ACK;
                n_tick    = '0;
                n_retries = retry_load;
            end else begin
                o_result.release_l = 1'b1;
                do_finish          = 1'b1;
                fin_code           = ST_SEND_FAIL;
            end
        end

        // Close the transaction
        if (do_finish) begin
            o_result.done   = 1'b1;
            o_result.status = fin_code;
            n_phase         = PH_IDLE;
            n_tick          = '0;
        end

        o_result.busy = (n_phase != PH_IDLE);
    end

    // Commit state when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_retries <= '0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_retries <= n_retries;
        end
    end

endmodule

`default_nettype wire

### rtl/core/locked_send_ack_timeout_ctrl_unit.sv
// Each item is registered in the input register, then in the result register; a full, stalled result register holds it.
// Throughput: one item per cycle; the input side keeps accepting while a result waits,
//   as long as the result register drains or is empty.
// Reset (i_rst_n low, synchronous): phase idle, counters zero, timeout 100, retries 0.
// Configuration writes take effect the cycle after they are accepted.
// ----------------------------------------------------------------------------
// locked_send_ack_timeout_ctrl_unit: locked message send controller
// Claims a shared lock, sends, waits for acknowledge with timeout and retries.
// ----------------------------------------------------------------------------
`default_nettype none

module locked_send_ack_timeout_ctrl_unit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration write channel
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [lsatc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [lsatc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input item channel
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  [lsatc_pkg::REQ_W-1:0]          i_req_type,
    input  wire                                  i_lock_free,
    input  wire                                  i_send_ok,
    // result item channel
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic                                 o_claim_pulse,
    output logic                                 o_send_pulse,
    output logic                                 o_release_pulse,
    output logic                                 o_busy_res,
    output logic                                 o_done_res,
    output logic [lsatc_pkg::STATUS_W-1:0]       o_status
);
    import lsatc_pkg::*;

    logic [TIMEOUT_W-1:0]   r_timeout;
    logic [ACKRET_W-1:0]    r_ack_retries;

    logic                   r_in_valid, n_in_valid;
    logic [REQ_W-1:0]       r_req;
    logic                   r_lock_free;
    logic                   r_send_ok;

    logic                   r_out_valid, n_out_valid;
    t_result                r_out;
    t_result                step_res;

    logic                   advance;
    logic                   in_take;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= TIMEOUT_RST;
            r_ack_retries <= ACKRET_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TIMEOUT: r_timeout     <= i_cfg_data[TIMEOUT_W-1:0];
                CFG_RETRIES: r_ack_retries <= i_cfg_data[ACKRET_W-1:0];
                default: ;
            endcase
        end
    end

    // Move the held item on when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    assign n_in_valid  = in_take || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && !i_out_ready);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req       <= i_req_type;
            r_lock_free <= i_lock_free;
            r_send_ok   <= i_send_ok;
        end
    end

    // State update and result logic
    lsatc_step u_step (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_req_type      (r_req),
        .i_lock_free     (r_lock_free),
        .i_send_ok       (r_send_ok),
        .i_timeout_ticks (r_timeout),
        .i_ack_retries   (r_ack_retries),
        .o_result        (step_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_claim_pulse   = r_out.claim;
    assign o_send_pulse    = r_out.send;
    assign o_release_pulse = r_out.release_l;
    assign o_busy_res      = r_out.busy;
    assign o_done_res      = r_out.done;
    assign o_status        = r_out.status;

endmodule

`default_nettype wire
